>>> sv/rcq_pkg.sv
package rcq_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int OP_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 2'd0,
      OP_REMOVE = 2'd1,
      OP_ROTATE = 2'd2,
      OP_SHOW   = 2'd3
   } opcode_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SHOW = 1'b1
   } state_type;

   typedef enum logic {
      KIND_ELEMENT = 1'b0,
      KIND_FAIL    = 1'b1
   } kind_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic              append;
      logic              shift;
      logic              rotate;
      logic [DATA_W-1:0] value;
   } cmd_type;

endpackage

>>> sv/rcq_cell.sv
module rcq_cell
   import rcq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  logic              prev_valid,
   input  logic              next_valid,
   input  logic [DATA_W-1:0] next_data,
   input  logic [DATA_W-1:0] front_data,
   output logic              valid,
   output logic [DATA_W-1:0] data
);

   logic              valid_ff, valid_in;
   logic [DATA_W-1:0] data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (cmd.append) begin
         // first empty cell behind the back takes the new value
         if (!valid_ff && prev_valid) begin
            valid_in = 1'b1;
            data_in  = cmd.value;
         end
      end else if (cmd.shift) begin
         valid_in = next_valid;
         data_in  = next_data;
      end else if (cmd.rotate) begin
         if (valid_ff && !next_valid) begin
            data_in = front_data;
         end else if (valid_ff) begin
            data_in = next_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

>>> sv/rcq_ctrl.sv
module rcq_ctrl
   import rcq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [OP_W-1:0]   req_opcode,
   input  logic [DATA_W-1:0] req_value,
   input  logic [DATA_W-1:0] front_data,
   output cmd_type           cmd,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic              rsp_kind,
   output logic [DATA_W-1:0] rsp_element,
   output logic              rsp_last
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  remain_ff, remain_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              out_free;
   logic              fail;
   opcode_type        op;

   assign op = opcode_type'(req_opcode);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      cmd          = '0;
      cmd.value    = req_value;
      fail         = 1'b0;
      out_free     = !rsp_valid_ff || rsp_tready;
      req_tready   = (state_ff == ST_IDLE) && out_free;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               case (op)
                  OP_APPEND: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        fail = 1'b1;
                     end else begin
                        cmd.append = 1'b1;
                        count_in   = count_ff + CNT_W'(1);
                     end
                  end
                  OP_REMOVE: begin
                     if (count_ff == '0) begin
                        fail = 1'b1;
                     end else begin
                        cmd.shift = 1'b1;
                        count_in  = count_ff - CNT_W'(1);
                     end
                  end
                  OP_ROTATE: begin
                     if (count_ff == '0) begin
                        fail = 1'b1;
                     end else begin
                        cmd.rotate = 1'b1;
                     end
                  end
                  OP_SHOW: begin
                     if (count_ff != '0) begin
                        state_in  = ST_SHOW;
                        remain_in = count_ff;
                     end
                  end
                  default: begin
                     fail = 1'b0;
                  end
               endcase
               if (fail) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_FAIL;
                  rsp_data_in  = '0;
                  rsp_last_in  = 1'b1;
               end
            end
         end
         ST_SHOW: begin
            // emit the front and spin it to the back; a full lap restores order
            if (out_free) begin
               cmd.rotate   = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ELEMENT;
               rsp_data_in  = front_data;
               rsp_last_in  = (remain_ff == CNT_W'(1));
               remain_in    = remain_ff - CNT_W'(1);
               if (remain_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_element = rsp_data_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

>>> sv/rotating_circular_queue.sv
// append, remove and rotate: one beat per cycle while the output is free; no result
// unless they fail; a failure result is registered, shown the cycle after its input beat
// show: the beat sets the show state, then one element per cycle while the output is free
//   goes to the output register; no input beat is taken until the last one is loaded
// reset (synchronous) empties the queue and the output register; cell data is not cleared
module rotating_circular_queue
   import rcq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,   // [31:0] value
   input  logic [1:0]        req_tuser,   // [1:0] opcode
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,   // [31:0] element
   output logic [0:0]        rsp_tuser,   // [0] kind
   output logic              rsp_tlast
);

   cmd_type           cmd;
   logic              valid_w [DEPTH];
   logic [DATA_W-1:0] data_w  [DEPTH];
   logic              rsp_kind;

   rcq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_opcode  (req_tuser),
      .req_value   (req_tdata),
      .front_data  (data_w[0]),
      .cmd         (cmd),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_kind    (rsp_kind),
      .rsp_element (rsp_tdata),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tuser = rsp_kind;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic              prev_valid;
      logic              next_valid;
      logic [DATA_W-1:0] next_data;

      if (i == 0) begin : g_head
         assign prev_valid = 1'b1;
      end else begin : g_body
         assign prev_valid = valid_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_valid = 1'b0;
         assign next_data  = data_w[i];
      end else begin : g_link
         assign next_valid = valid_w[i+1];
         assign next_data  = data_w[i+1];
      end

      rcq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .prev_valid (prev_valid),
         .next_valid (next_valid),
         .next_data  (next_data),
         .front_data (data_w[0]),
         .valid      (valid_w[i]),
         .data       (data_w[i])
      );
   end

endmodule

>>> sv/rcq_checker.sv
module rcq_checker
   import rcq_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [0:0]  rsp_tuser,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   a_fail_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 32'd0 && rsp_tlast)
      else $error("failure beat not zero or not last");

   // no input beat is taken while a show stream is still running
   a_show_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input taken in the middle of a show stream");

endmodule

bind rotating_circular_queue rcq_checker u_rcq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
